### hw/rtl/rstab_pkg.sv
// ----------------------------------------------------------------------------
// rstab_pkg
// types and constants shared by the reply slot table modules
// ----------------------------------------------------------------------------
package rstab_pkg;

  typedef enum logic [2:0] {
    CMD_TAKE    = 3'd0,
    CMD_APPEND  = 3'd1,
    CMD_NEXT    = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_CLOSE   = 3'd4,
    CMD_FREE    = 3'd5,
    CMD_RSVD6   = 3'd6,
    CMD_RSVD7   = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    RC_OK          = 4'd0,
    RC_ALL_TAKEN   = 4'd1,
    RC_NOT_FOUND   = 4'd2,
    RC_NOT_USED    = 4'd3,
    RC_COMPLETE    = 4'd4,
    RC_SEGMENT     = 4'd5,
    RC_DROPPED     = 4'd6,
    RC_NO_MORE     = 4'd7,
    RC_WOULD_BLOCK = 4'd8,
    RC_CLOSED      = 4'd9,
    RC_FULL        = 4'd10
  } code_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ALL         = 2'd1,
    ST_ITER_CLOSED = 2'd2,
    ST_CLOSED      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_TPROBE,
    S_RD,
    S_CMP,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    RT_DIRECT,
    RT_MOD,
    RT_READ
  } route_e;

  localparam int unsigned IdW  = 31;
  localparam int unsigned SegW = 16;
  localparam int unsigned SumW = 32;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [IdW-1:0]  request_id;
    logic [3:0]      slot_index;
    logic [SegW-1:0] segment_number;
    logic            last_segment;
  } in_item_t;

  typedef struct packed {
    logic [3:0] result_slot;
    logic [3:0] result_code;
    logic       last_reply;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic take_step;
    logic rd;
    logic cmp;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    route_e route;
    logic   is_take;
    logic   mod_last;
    logic   take_end;
    logic   cmp_end;
  } sts_t;

endpackage

### hw/rtl/reply_slot_table_core.sv
// ----------------------------------------------------------------------------
// reply_slot_table_core
// table of request slots with reply counting, one command per beat
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | in_i  (in_item_t)
//  out     | output    | out_valid_o / out_stall_i | out_o (out_item_t)
//
// take: folding modulo reduction, then one probe step per slot probed
// append: folding modulo reduction, then a memory read and a compare per slot probed
// next, release, free: a memory read and a compare; close all and bad indexes: straight to the result
// reset clears slot flags and offsets at once; no clearing pass is needed
// a new beat is taken while a finished result still waits in the output register
module reply_slot_table_core import rstab_pkg::*; #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned QUEUE_DEPTH = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  ctl_t ctl;
  sts_t sts;

  rstab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rstab_dp #(
    .SLOTS       (SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .out_o  (out_o)
  );

endmodule

### hw/rtl/rstab_ctrl.sv
// ----------------------------------------------------------------------------
// rstab_ctrl
// sequencer of the reply slot table: steps the datapath through reduce,
// probe and read-modify-write phases and owns the handshakes
// ----------------------------------------------------------------------------
module rstab_ctrl import rstab_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.route)
            RT_MOD:  state_d = S_MOD;
            RT_READ: state_d = S_RD;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_MOD: begin
        if (sts_i.mod_last) state_d = sts_i.is_take ? S_TPROBE : S_RD;
      end
      S_TPROBE: begin
        if (sts_i.take_end) state_d = S_DONE;
      end
      S_RD:  state_d = S_CMP;
      S_CMP: state_d = sts_i.cmp_end ? S_DONE : S_RD;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    case (state_q)
      S_IDLE:   ctl_o.load = in_valid_i;
      S_MOD:    ctl_o.mod_step = 1'b1;
      S_TPROBE: ctl_o.take_step = 1'b1;
      S_RD:     ctl_o.rd = 1'b1;
      S_CMP:    ctl_o.cmp = 1'b1;
      S_DONE:   ctl_o.out_load = out_free;
      default:  ctl_o = '0;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (ctl_o.out_load) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

### hw/rtl/rstab_dp.sv
// ----------------------------------------------------------------------------
// rstab_dp
// datapath of the reply slot table: slot flags, slot memory, folding
// modulo reducer, probe pointer and result registers
// ----------------------------------------------------------------------------
module rstab_dp import rstab_pkg::*; #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned QUEUE_DEPTH = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_i,
  input  ctl_t      ctl_i,
  output sts_t      sts_o,
  output out_item_t out_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned PW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = IdW + SegW + PW;
  localparam logic [SW:0]   SlotsW  = (SW+1)'(SLOTS);
  localparam logic [SW-1:0] SlotMax = SW'(SLOTS - 1);
  localparam logic [PW-1:0] QdW     = PW'(QUEUE_DEPTH);
  localparam int unsigned   RecK    = 16 + SW;
  localparam logic [8:0]    FoldC   = 9'((32'd1 << 16) % SLOTS);
  localparam logic [17:0]   RecM    = 18'(((32'd1 << RecK) + SLOTS - 1) / SLOTS);
  localparam logic [15:0]   SlotsH  = 16'(SLOTS);

  typedef struct packed {
    logic [IdW-1:0]  req;
    logic [SegW-1:0] exp;
    logic [PW-1:0]   pend;
  } entry_t;

  cmd_e            cmd_q;
  logic [IdW-1:0]  id_q;
  logic [SegW-1:0] seg_q;
  logic            last_q;
  logic [SumW-1:0] red_q;
  logic [15:0]     quo_q;
  logic            quo_v_q;
  logic [SW-1:0]   ptr_q, ptr_d;
  logic [SW-1:0]   tries_q;
  logic            dir_q;
  logic [SW-1:0]   take_off_q, ans_off_q;
  logic            used_q [SLOTS];
  status_e         status_q [SLOTS];
  logic            wvld_q [SLOTS];
  logic [EW-1:0]   mem [SLOTS];
  logic [EW-1:0]   rd_q;
  logic            rdv_q;
  out_item_t       res_q, out_q;

  cmd_e   in_cmd;
  route_e route;
  logic   idx_bad;
  entry_t ent;
  logic   match, bwd;
  logic [SumW-1:0] fold_sum;
  logic [33:0]     rec_prod;
  logic [15:0]     rem_w;
  logic [SW-1:0] ptr_fwd, ptr_bwd;
  logic [SW:0]   tsum, asum;
  logic [SW-1:0] tmod, amod;

  logic      wr_en;
  entry_t    wr_data;
  logic      used_we, used_val;
  logic      st_we;
  status_e   st_val;
  logic      ans_we, wvld_set, cmp_end;
  logic      step;
  out_item_t cmp_res;
  status_e   st_cur;
  logic      used_cur;

  assign in_cmd  = cmd_e'(in_i.cmd);
  assign idx_bad = (32'(in_i.slot_index) >= 32'(SLOTS));

  always_comb begin
    case (in_cmd)
      CMD_TAKE, CMD_APPEND:            route = RT_MOD;
      CMD_NEXT, CMD_RELEASE, CMD_FREE: route = idx_bad ? RT_DIRECT : RT_READ;
      default:                         route = RT_DIRECT;
    endcase
  end

  assign sts_o.route = route;

  // fold the upper half back in, then reciprocal quotient on 16 bits
  assign fold_sum = SumW'(red_q[SumW-1:16] * FoldC) + SumW'(red_q[15:0]);
  assign rec_prod = 34'(red_q[15:0]) * 34'(RecM);
  assign rem_w    = red_q[15:0] - quo_q * SlotsH;

  assign ptr_fwd = (ptr_q == SlotMax) ? '0 : ptr_q + 1'b1;
  assign ptr_bwd = (ptr_q == '0) ? SlotMax : ptr_q - 1'b1;

  assign tsum = {1'b0, take_off_q} + {1'b0, tries_q};
  assign tmod = (tsum >= SlotsW) ? SW'(tsum - SlotsW) : SW'(tsum);
  assign asum = {1'b0, ans_off_q} + {1'b0, tries_q};
  assign amod = (asum >= SlotsW) ? SW'(asum - SlotsW) : SW'(asum);

  assign used_cur = used_q[ptr_q];
  assign st_cur   = status_q[ptr_q];

  assign sts_o.is_take  = (cmd_q == CMD_TAKE);
  assign sts_o.mod_last = quo_v_q;
  assign sts_o.take_end = !used_cur || (tries_q == SlotMax);
  assign sts_o.cmp_end  = cmp_end;

  assign ent   = rdv_q ? entry_t'(rd_q) : '0;
  assign match = (ent.req == id_q);
  assign bwd   = (tries_q == '0) ? (ent.req > id_q) : dir_q;

  always_comb begin
    wr_en    = 1'b0;
    wr_data  = ent;
    used_we  = 1'b0;
    used_val = 1'b0;
    st_we    = 1'b0;
    st_val   = ST_OK;
    ans_we   = 1'b0;
    cmp_end  = 1'b1;
    step     = 1'b0;
    cmp_res  = '{result_slot: 4'(ptr_q), result_code: RC_OK, last_reply: 1'b0};
    case (cmd_q)
      CMD_APPEND: begin
        if (!match) begin
          if (tries_q == SlotMax) begin
            cmp_res = '{result_slot: 4'd0, result_code: RC_NOT_FOUND, last_reply: 1'b0};
          end else begin
            cmp_end = 1'b0;
            step    = 1'b1;
          end
        end else begin
          ans_we = !bwd;
          if (!used_cur) begin
            cmp_res.result_code = RC_NOT_USED;
          end else if (st_cur == ST_ALL) begin
            cmp_res.result_code = RC_COMPLETE;
          end else if (ent.exp != seg_q) begin
            cmp_res.result_code = RC_SEGMENT;
          end else if (st_cur == ST_ITER_CLOSED) begin
            cmp_res.result_code = RC_DROPPED;
            if (last_q) begin
              wr_en        = 1'b1;
              wr_data.pend = '0;
              used_we      = 1'b1;
              st_we        = 1'b1;
            end
          end else if (ent.pend >= QdW) begin
            cmp_res.result_code = RC_FULL;
          end else begin
            wr_en        = 1'b1;
            wr_data.pend = ent.pend + 1'b1;
            wr_data.exp  = ent.exp + 1'b1;
            if (last_q) begin
              st_we  = 1'b1;
              st_val = ST_ALL;
            end
          end
        end
      end
      CMD_NEXT: begin
        if (st_cur == ST_ITER_CLOSED) begin
          cmp_res.result_code = RC_FULL;
        end else if (st_cur == ST_ALL && ent.pend == '0) begin
          cmp_res.result_code = RC_NO_MORE;
        end else if (st_cur == ST_CLOSED) begin
          cmp_res.result_code = RC_CLOSED;
        end else if (ent.pend == '0) begin
          cmp_res.result_code = RC_WOULD_BLOCK;
        end else begin
          wr_en        = 1'b1;
          wr_data.pend = ent.pend - 1'b1;
          cmp_res.last_reply = (ent.pend == PW'(1)) && (st_cur == ST_ALL);
        end
      end
      CMD_RELEASE: begin
        wr_en        = 1'b1;
        wr_data.pend = '0;
        st_we        = 1'b1;
        if (st_cur == ST_ALL) used_we = 1'b1;
        else st_val = ST_ITER_CLOSED;
      end
      CMD_FREE: begin
        wr_en        = 1'b1;
        wr_data.pend = '0;
        used_we      = 1'b1;
        st_we        = 1'b1;
      end
      default: begin
        cmp_end = 1'b1;
      end
    endcase
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctl_i.load) begin
      ptr_d = (route == RT_READ) ? SW'(in_i.slot_index) : '0;
    end else if (ctl_i.mod_step && quo_v_q) begin
      ptr_d = SW'(rem_w);
    end else if (ctl_i.take_step && used_cur && tries_q != SlotMax) begin
      ptr_d = ptr_fwd;
    end else if (ctl_i.cmp && step) begin
      ptr_d = bwd ? ptr_bwd : ptr_fwd;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (ctl_i.load) begin
      cmd_q   <= in_cmd;
      id_q    <= in_i.request_id;
      seg_q   <= in_i.segment_number;
      last_q  <= in_i.last_segment;
      red_q   <= SumW'(in_i.request_id)
               + SumW'((in_cmd == CMD_TAKE) ? take_off_q : ans_off_q);
      quo_v_q <= 1'b0;
      tries_q <= '0;
      if (idx_bad && (in_cmd == CMD_NEXT || in_cmd == CMD_RELEASE || in_cmd == CMD_FREE))
        res_q <= '{result_slot: in_i.slot_index, result_code: RC_NOT_FOUND, last_reply: 1'b0};
      else
        res_q <= '{result_slot: 4'd0, result_code: RC_OK, last_reply: 1'b0};
    end
    if (ctl_i.mod_step) begin
      if (red_q[SumW-1:16] != '0) begin
        red_q <= fold_sum;
      end else begin
        quo_q   <= 16'(rec_prod >> RecK);
        quo_v_q <= 1'b1;
      end
    end
    if (ctl_i.take_step) begin
      if (!used_cur)
        res_q <= '{result_slot: 4'(ptr_q), result_code: RC_OK, last_reply: 1'b0};
      else if (tries_q == SlotMax)
        res_q <= '{result_slot: 4'd0, result_code: RC_ALL_TAKEN, last_reply: 1'b0};
      else
        tries_q <= tries_q + 1'b1;
    end
    if (ctl_i.rd) begin
      rd_q <= mem[ptr_q];
    end
    if (ctl_i.cmp) begin
      dir_q <= bwd;
      if (step) tries_q <= tries_q + 1'b1;
      if (cmp_end) res_q <= cmp_res;
    end
    if (ctl_i.cmp && wr_en) begin
      mem[ptr_q] <= wr_data;
    end else if (ctl_i.take_step && !used_cur) begin
      mem[ptr_q] <= {id_q, {SegW{1'b0}}, {PW{1'b0}}};
    end
    if (ctl_i.out_load) out_q <= res_q;
  end

  assign wvld_set = (ctl_i.cmp && wr_en) || (ctl_i.take_step && !used_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        used_q[i]   <= 1'b0;
        status_q[i] <= ST_OK;
        wvld_q[i]   <= 1'b0;
      end
      take_off_q <= '0;
      ans_off_q  <= '0;
      rdv_q      <= 1'b0;
    end else begin
      if (ctl_i.rd) rdv_q <= wvld_q[ptr_q];
      if (wvld_set) wvld_q[ptr_q] <= 1'b1;
      if (ctl_i.load && in_cmd == CMD_CLOSE) begin
        for (int i = 0; i < SLOTS; i++) status_q[i] <= ST_CLOSED;
      end
      if (ctl_i.take_step && !used_cur) begin
        used_q[ptr_q]   <= 1'b1;
        status_q[ptr_q] <= ST_OK;
        take_off_q      <= tmod;
      end
      if (ctl_i.cmp) begin
        if (used_we) used_q[ptr_q] <= used_val;
        if (st_we) status_q[ptr_q] <= st_val;
        if (ans_we) ans_off_q <= amod;
      end
    end
  end

  assign out_o = out_q;

endmodule
